/* rtl/lwub_pkg.sv */
// Package for the longest window under budget block: sizes, widths and the
// command/status structs shared by the controller and the datapath.
// No dependencies.
package lwub_pkg;

  // Ring buffer depth; lengths saturate here.
  localparam int MAX_WINDOW = 1024;

  localparam int PRICE_W  = 10;
  localparam int BUDGET_W = 20;
  localparam int COUNT_W  = 11;

  localparam int PTR_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W = LEN_W + 1;
  // Window total before trimming is at most budget + one price.
  localparam int SUM_W  = BUDGET_W + 1;

  typedef struct packed {
    logic push;    // take the new item into the window
    logic pop;     // drop the front entry
    logic finish;  // load the result and close the item
  } cmd_t;

  typedef struct packed {
    logic over;    // window non-empty and total above budget
  } status_t;

endpackage

/* rtl/lwub_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lwub_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lwub_ctrl.sv */
// Sequencer for the longest window under budget block: input handshake,
// trim loop and output valid. Uses lwub_pkg.
module lwub_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  lwub_pkg::status_t status_i,
  output lwub_pkg::cmd_t    cmd_o
);

  typedef enum logic [0:0] {
    S_IDLE,
    S_TRIM
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.push = 1'b1;
          state_d    = S_TRIM;
        end
      end
      S_TRIM: begin
        if (status_i.over) begin
          cmd_o.pop = 1'b1;
        end else if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // A held result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !cmd_o.finish)
    else $error("result overwritten while stalled");

  // Every accepted item is followed by the trim loop.
  a_push_to_trim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |=> (state_q == S_TRIM))
    else $error("push did not enter trim");

  // No result is produced while the window is still over budget.
  a_finish_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> !status_i.over)
    else $error("finish while over budget");

endmodule

/* rtl/lwub_dp.sv */
// Datapath for the longest window under budget block: budget register,
// price ring buffer, window pointers, totals and result registers.
// Uses lwub_pkg and lwub_ram.
module lwub_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lwub_pkg::BUDGET_W-1:0]    cfg_wdata_i,
  input  logic [lwub_pkg::PRICE_W-1:0]     price_i,
  input  logic                             last_i,
  input  lwub_pkg::cmd_t                   cmd_i,
  output lwub_pkg::status_t                status_o,
  output logic [lwub_pkg::COUNT_W-1:0]     best_count_o,
  output logic [lwub_pkg::COUNT_W-1:0]     window_count_o,
  output logic                             final_res_o
);

  localparam int PTR_W   = lwub_pkg::PTR_W;
  localparam int LEN_W   = lwub_pkg::LEN_W;
  localparam int SLOT_W  = lwub_pkg::SLOT_W;
  localparam int SUM_W   = lwub_pkg::SUM_W;
  localparam int PRICE_W = lwub_pkg::PRICE_W;
  localparam int COUNT_W = lwub_pkg::COUNT_W;

  logic [lwub_pkg::BUDGET_W-1:0] budget_q;
  logic [PTR_W-1:0]   front_q, front_d, front_inc, slot, waddr;
  logic [LEN_W-1:0]   len_q, len_d, best_q, best_d, best_new;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [PRICE_W-1:0] price_q, price_d, rdata, pop_val;
  logic               last_q, last_d;
  logic [SLOT_W-1:0]  slot_sum;
  logic               full;
  logic [COUNT_W-1:0] best_cnt_q, best_cnt_d, win_cnt_q, win_cnt_d;
  logic               final_q, final_d;

  lwub_ram #(
    .WIDTH(PRICE_W),
    .DEPTH(lwub_pkg::MAX_WINDOW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(waddr),
    .wdata_i(price_i),
    .raddr_i(front_d),
    .rdata_o(rdata)
  );

  always_comb begin
    full      = (len_q == LEN_W'(lwub_pkg::MAX_WINDOW));
    // A lone entry is the item just written; its read may be stale.
    pop_val   = (len_q == LEN_W'(1)) ? price_q : rdata;
    front_inc = (front_q == PTR_W'(lwub_pkg::MAX_WINDOW - 1)) ? '0 : front_q + PTR_W'(1);
    slot_sum  = SLOT_W'(front_q) + SLOT_W'(len_q);
    slot      = (slot_sum >= SLOT_W'(lwub_pkg::MAX_WINDOW)) ?
                PTR_W'(slot_sum - SLOT_W'(lwub_pkg::MAX_WINDOW)) : PTR_W'(slot_sum);
    best_new  = (len_q > best_q) ? len_q : best_q;

    front_d    = front_q;
    len_d      = len_q;
    sum_d      = sum_q;
    best_d     = best_q;
    price_d    = price_q;
    last_d     = last_q;
    waddr      = slot;
    best_cnt_d = best_cnt_q;
    win_cnt_d  = win_cnt_q;
    final_d    = final_q;

    if (cmd_i.push) begin
      price_d = price_i;
      last_d  = last_i;
      if (full) begin
        // Drop the oldest entry; the new price takes its slot.
        waddr   = front_q;
        front_d = front_inc;
        sum_d   = sum_q - SUM_W'(rdata) + SUM_W'(price_i);
      end else begin
        len_d = len_q + LEN_W'(1);
        sum_d = sum_q + SUM_W'(price_i);
      end
    end else if (cmd_i.pop) begin
      front_d = front_inc;
      len_d   = len_q - LEN_W'(1);
      sum_d   = sum_q - SUM_W'(pop_val);
    end else if (cmd_i.finish) begin
      best_cnt_d = COUNT_W'(best_new);
      win_cnt_d  = COUNT_W'(len_q);
      final_d    = last_q;
      if (last_q) begin
        front_d = '0;
        len_d   = '0;
        sum_d   = '0;
        best_d  = '0;
      end else begin
        best_d = best_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= '0;
      front_q  <= '0;
      len_q    <= '0;
      sum_q    <= '0;
      best_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        budget_q <= cfg_wdata_i;
      end
      front_q <= front_d;
      len_q   <= len_d;
      sum_q   <= sum_d;
      best_q  <= best_d;
    end
  end

  always_ff @(posedge clk_i) begin
    price_q    <= price_d;
    last_q     <= last_d;
    best_cnt_q <= best_cnt_d;
    win_cnt_q  <= win_cnt_d;
    final_q    <= final_d;
  end

  assign status_o.over  = (len_q != '0) && (sum_q > SUM_W'(budget_q));
  assign best_count_o   = best_cnt_q;
  assign window_count_o = win_cnt_q;
  assign final_res_o    = final_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LEN_W'(lwub_pkg::MAX_WINDOW))
    else $error("window length above depth");

  a_empty_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q == '0) |-> (sum_q == '0))
    else $error("empty window with nonzero total");

  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> (len_q != '0))
    else $error("window empty after push");

  a_best_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.finish && !last_q) |=> (best_q >= $past(len_q)))
    else $error("best length below window length");

endmodule

/* rtl/longest_window_under_budget.sv */
// Top level of the longest window under budget block.
// Instantiates lwub_ctrl and lwub_dp; uses lwub_pkg.
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i/in_stall_o    price_i[9:0], last_i
//   out      out  out_valid_o/out_stall_i  best_count_o[10:0], window_count_o[10:0],
//                                          final_res_o
//   cfg      in   cfg_we_i                 cfg_wdata_i[19:0] (budget)
//
// Steps: an item is accepted and pushed, then P pops, then the result, P being
// the entries trimmed from the window front, one per cycle through the ring
// buffer's single read port. Each entry is popped at most once, and no new item
// is taken until the last one has loaded its result. Reset clears the window and
// the budget at once; the ring buffer needs no clearing since only written
// entries are ever read.
// A stalled result sits in the output register while the next item is taken;
// only the finish of that next item waits for the output to drain.
module longest_window_under_budget (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lwub_pkg::BUDGET_W-1:0] cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lwub_pkg::PRICE_W-1:0]  price_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lwub_pkg::COUNT_W-1:0]  best_count_o,
  output logic [lwub_pkg::COUNT_W-1:0]  window_count_o,
  output logic                          final_res_o
);

  lwub_pkg::cmd_t    cmd;
  lwub_pkg::status_t status;

  // Sequencer: idle -> push (one cycle) -> trim loop -> result.
  lwub_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Ring buffer, window total and result registers.
  lwub_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .price_i       (price_i),
    .last_i        (last_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .best_count_o  (best_count_o),
    .window_count_o(window_count_o),
    .final_res_o   (final_res_o)
  );

endmodule

/* test/tb_longest_window_under_budget.sv */
// Self-checking testbench for longest_window_under_budget: a directed table, then random
// price sets under changing budgets and idling, each result checked against a window model.
// Depends on lwub_pkg and the RTL top level; reads nothing else.
module tb_longest_window_under_budget;
  timeunit 1ns;
  timeprecision 1ps;

  import lwub_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DIRECTED_N  = 18;
  localparam bit [BUDGET_W-1:0] BUDGET_MAX = '1;

  // One expected result: counts plus the end-of-set flag.
  typedef struct packed {
    logic [COUNT_W-1:0] best;
    logic [COUNT_W-1:0] win;
    logic               fin;
  } outcome_t;

  // Directed row: budget in force, the item, and optionally the result by hand.
  typedef struct packed {
    bit [BUDGET_W-1:0] budget;
    bit [PRICE_W-1:0]  price;
    bit                last;
    bit                typed;
    bit [COUNT_W-1:0]  best;
    bit [COUNT_W-1:0]  win;
  } row_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [BUDGET_W-1:0] cfg_wdata_i = '0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [PRICE_W-1:0]  price_i     = '0;
  logic                last_i      = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [COUNT_W-1:0]  best_count_o;
  logic [COUNT_W-1:0]  window_count_o;
  logic                final_res_o;

  longest_window_under_budget dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .price_i        (price_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .best_count_o   (best_count_o),
    .window_count_o (window_count_o),
    .final_res_o    (final_res_o)
  );

  always #5 clk_i = ~clk_i;

  // Window model state, mirrors the block's ring buffer and running totals.
  bit [PRICE_W-1:0] ring_prices [MAX_WINDOW];
  int unsigned      front_idx  = 0;
  int unsigned      win_len    = 0;
  int unsigned      win_sum    = 0;
  int unsigned      best_len   = 0;
  int unsigned      budget_now = 0;

  outcome_t pending_counts [$];
  int       mismatch_count = 0;
  int       results_seen   = 0;
  int       cycle_count    = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;

  // Hand-checked results only for the obvious rows: zero budget, maximum
  // budget with no trimming, a single item at exactly the budget, and a
  // price over the budget. The trimming rows go through the model.
  row_t directed_rows [DIRECTED_N] = '{
    '{20'd0,      10'd1,    1'b0, 1'b1, 11'd0, 11'd0},
    '{20'd0,      10'd0,    1'b1, 1'b1, 11'd1, 11'd1},
    '{20'hFFFFF,  10'd1023, 1'b0, 1'b1, 11'd1, 11'd1},
    '{20'hFFFFF,  10'd1000, 1'b0, 1'b1, 11'd2, 11'd2},
    '{20'hFFFFF,  10'd1,    1'b1, 1'b1, 11'd3, 11'd3},
    '{20'd5,      10'd3,    1'b0, 1'b0, 11'd0, 11'd0},
    '{20'd5,      10'd2,    1'b0, 1'b0, 11'd0, 11'd0},
    '{20'd5,      10'd1,    1'b0, 1'b0, 11'd0, 11'd0},
    '{20'd5,      10'd6,    1'b0, 1'b0, 11'd0, 11'd0},
    '{20'd5,      10'd1,    1'b0, 1'b0, 11'd0, 11'd0},
    '{20'd5,      10'd1,    1'b0, 1'b0, 11'd0, 11'd0},
    '{20'd5,      10'd1,    1'b0, 1'b0, 11'd0, 11'd0},
    '{20'd5,      10'd2,    1'b1, 1'b0, 11'd0, 11'd0},
    '{20'd5,      10'd5,    1'b1, 1'b1, 11'd1, 11'd1},
    '{20'd5,      10'd512,  1'b1, 1'b1, 11'd0, 11'd0},
    '{20'd1000,   10'd1000, 1'b0, 1'b0, 11'd0, 11'd0},
    '{20'd1000,   10'd1,    1'b0, 1'b0, 11'd0, 11'd0},
    '{20'd1000,   10'd999,  1'b1, 1'b0, 11'd0, 11'd0}
  };

  function automatic void drop_front();
    win_sum  -= ring_prices[front_idx];
    front_idx = (front_idx + 1) % MAX_WINDOW;
    win_len--;
  endfunction

  // Push one price, trim the front until the total fits, report the counts.
  function automatic outcome_t advance_window(bit [PRICE_W-1:0] price, bit last);
    outcome_t res;
    if (win_len >= MAX_WINDOW) drop_front();  // full: oldest entry falls out
    ring_prices[(front_idx + win_len) % MAX_WINDOW] = price;
    win_len++;
    win_sum += price;
    while (win_len > 0 && win_sum > budget_now) drop_front();
    if (win_len > best_len) best_len = win_len;
    res.best = COUNT_W'(best_len);
    res.win  = COUNT_W'(win_len);
    res.fin  = last;
    if (last) begin
      front_idx = 0;
      win_len   = 0;
      win_sum   = 0;
      best_len  = 0;
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] result %0d: %s", $time, results_seen, msg);
    mismatch_count++;
  endtask

  // Offer one item; optional idle cycles first. Valid stays high on return
  // so back-to-back items never toggle it within one step.
  task automatic send_item(input bit [PRICE_W-1:0] price, input bit last,
                           input bit typed, input bit [COUNT_W-1:0] best,
                           input bit [COUNT_W-1:0] win);
    outcome_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    price_i    <= price;
    last_i     <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    res = advance_window(price, last);
    if (typed) begin
      res.best = best;
      res.win  = win;
    end
    pending_counts = {pending_counts, res};
  endtask

  // Hold off the sender until every outstanding result has been taken.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_counts.size() != 0);
  endtask

  // Caller guarantees the block is idle.
  task automatic write_budget(input bit [BUDGET_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    budget_now = value;
    cfg_we_i   <= 1'b0;
  endtask

  function automatic bit [BUDGET_W-1:0] choose_budget();
    case ($urandom_range(5))
      0:       return '0;
      1:       return BUDGET_MAX;
      2:       return BUDGET_W'($urandom_range(1, 1000));
      3:       return BUDGET_W'($urandom_range(1000, 10000));
      4:       return BUDGET_W'($urandom_range(BUDGET_MAX));
      default: return BUDGET_W'($urandom_range(1000, 5000));
    endcase
  endfunction

  // Mostly prices that keep a handful of items in the window, some noise
  // over the whole field including zero and above the nominal range.
  function automatic bit [PRICE_W-1:0] choose_price();
    int unsigned cap;
    cap = budget_now / 3;
    if (cap < 1) cap = 1;
    if (cap > 1000) cap = 1000;
    if ($urandom_range(99) < 15) return PRICE_W'($urandom_range(1023));
    return PRICE_W'($urandom_range(cap, 1));
  endfunction

  task automatic run_random_sets(input int item_goal);
    int sent;
    int set_len;
    sent = 0;
    while (sent < item_goal) begin
      if ($urandom_range(7) == 0) begin
        drain_results();
        write_budget(choose_budget());
      end
      set_len = $urandom_range(1, 24);
      for (int k = 0; k < set_len; k++) begin
        send_item(choose_price(), k == set_len - 1, 1'b0, '0, '0);
        sent++;
      end
    end
  endtask

  // Result checker; samples pre-edge values and drives the random stall.
  always @(posedge clk_i) begin : watch_results
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_counts.size() == 0) begin
        flag_mismatch("unexpected result");
      end else begin
        want = pending_counts.pop_front();
        if (best_count_o !== want.best)
          flag_mismatch($sformatf("best_count %0d, want %0d", best_count_o, want.best));
        if (window_count_o !== want.win)
          flag_mismatch($sformatf("window_count %0d, want %0d", window_count_o, want.win));
        if (final_res_o !== want.fin)
          flag_mismatch($sformatf("final_res %0b, want %0b", final_res_o, want.fin));
      end
      results_seen++;
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Sender idles a little, receiver a lot.
    send_idle_pct  = 13;
    recv_stall_pct = 75;
    foreach (directed_rows[i]) begin
      if (i == 0 || directed_rows[i].budget != budget_now) begin
        drain_results();
        write_budget(directed_rows[i].budget);
      end
      send_item(directed_rows[i].price, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].best, directed_rows[i].win);
    end
    run_random_sets(400);

    drain_results();
    send_idle_pct  = 75;
    recv_stall_pct = 13;
    run_random_sets(400);

    drain_results();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_sets(150);

    // One set longer than the ring so the window fills and lengths saturate;
    // at the top budget even a full window of maximum prices never trims.
    drain_results();
    write_budget(BUDGET_MAX);
    for (int k = 0; k < MAX_WINDOW + 6; k++)
      send_item(PRICE_W'($urandom_range(1023)), k == MAX_WINDOW + 5, 1'b0, '0, '0);

    drain_results();
    repeat (20) @(posedge clk_i);
    if (pending_counts.size() != 0) flag_mismatch("results never arrived");
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
